// ===== src/wtsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wtsd_pkg
// shared constants, controller states and the command bundle of the
// weighted tardiness subset dp unit
// ----------------------------------------------------------------------------
package wtsd_pkg;

  // defaults of the top level parameters
  localparam int unsigned MaxJobsDef    = 12;
  localparam int unsigned FieldWidthDef = 16;

  // cost word, saturating at all ones
  localparam int unsigned CostW = 48;
  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SUM,
    ST_CAND,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_WRITE,
    ST_FINISH
  } wtsd_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // store the incoming job at the load index
    logic sum_en;      // accumulate completion time over job k
    logic sum_first;   // first step of the sum, also restarts the minimum
    logic cand_issue;  // launch the candidate of job k into the pipeline
    logic write_en;    // store the minimum as the cost of the current subset
    logic clr_ovf;     // a new run starts, forget earlier saturation
    logic out_load;    // copy the full-set cost into the result register
  } wtsd_cmd_t;

endpackage

// ===== src/wtsd_if.sv =====
// ----------------------------------------------------------------------------
// wtsd_if
// valid/ready channels of the unit: job input and cost result
// ----------------------------------------------------------------------------
interface wtsd_job_if #(
  parameter int unsigned FIELD_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] proc_time;
  logic [FIELD_WIDTH-1:0] weight;
  logic [FIELD_WIDTH-1:0] deadline;
  logic                   last_job;

  modport source (output valid, proc_time, weight, deadline, last_job, input ready);
  modport sink   (input valid, proc_time, weight, deadline, last_job, output ready);
endinterface

interface wtsd_res_if;
  logic        valid;
  logic        ready;
  logic [47:0] min_cost;
  logic        saturated;

  modport source (output valid, min_cost, saturated, input ready);
  modport sink   (input valid, min_cost, saturated, output ready);
endinterface

// ===== src/wtsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// wtsd_ctrl
// sequencer: job loading, subset and job counters, handshakes
// ----------------------------------------------------------------------------
module wtsd_ctrl #(
  parameter int unsigned MAX_JOBS = 12,
  parameter int unsigned CNT_W    = 4,
  parameter int unsigned IDX_W    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  logic                job_last_i,
  output logic                job_ready_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output wtsd_pkg::wtsd_cmd_t cmd_o,
  output logic [IDX_W-1:0]    load_idx_o,
  output logic [IDX_W-1:0]    k_o,
  output logic [MAX_JOBS-1:0] set_o
);
  import wtsd_pkg::*;

  wtsd_state_e         state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    k_q, k_d;
  logic [MAX_JOBS-1:0] set_q, set_d;
  logic                out_valid_q, out_valid_d;
  logic [MAX_JOBS-1:0] full_mask;
  logic                k_last;
  logic                set_last;
  logic                job_acc;

  always_comb begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      full_mask[i] = (CNT_W'(i) < cnt_q);
    end
  end

  assign k_last   = (CNT_W'(k_q) == (cnt_q - CNT_W'(1)));
  assign set_last = (set_q == full_mask);
  assign job_acc  = job_valid_i && job_ready_o;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    set_d       = set_q;
    cmd_o       = '0;
    job_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        job_ready_o = 1'b1;
        if (job_acc) begin
          if (cnt_q < CNT_W'(MAX_JOBS)) begin
            cmd_o.load = 1'b1;
            cnt_d      = cnt_q + CNT_W'(1);
          end
          if (job_last_i) begin
            cmd_o.clr_ovf = 1'b1;
            set_d         = MAX_JOBS'(1);
            k_d           = '0;
            state_d       = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        cmd_o.sum_en    = 1'b1;
        cmd_o.sum_first = (k_q == '0);
        if (k_last) begin
          k_d     = '0;
          state_d = ST_CAND;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      ST_CAND: begin
        cmd_o.cand_issue = 1'b1;
        if (k_last) begin
          k_d     = '0;
          state_d = ST_DRAIN1;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_WRITE;
      ST_WRITE: begin
        cmd_o.write_en = 1'b1;
        if (set_last) begin
          state_d = ST_FINISH;
        end else begin
          set_d   = set_q + MAX_JOBS'(1);
          state_d = ST_SUM;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || res_ready_i) begin
          cmd_o.out_load = 1'b1;
          cnt_d          = '0;
          state_d        = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      k_q         <= '0;
      set_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      set_q       <= set_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign load_idx_o  = cnt_q[IDX_W-1:0];
  assign k_o         = k_q;
  assign set_o       = set_q;
  assign res_valid_o = out_valid_q;

endmodule

// ===== src/wtsd_dpath.sv =====
// ----------------------------------------------------------------------------
// wtsd_dpath
// job store, completion-time accumulator, candidate pipeline, cost memory
// ----------------------------------------------------------------------------
module wtsd_dpath #(
  parameter int unsigned MAX_JOBS    = 12,
  parameter int unsigned FIELD_WIDTH = 16,
  parameter int unsigned CNT_W       = 4,
  parameter int unsigned IDX_W       = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wtsd_pkg::wtsd_cmd_t       cmd_i,
  input  logic [IDX_W-1:0]          load_idx_i,
  input  logic [IDX_W-1:0]          k_i,
  input  logic [MAX_JOBS-1:0]       set_i,
  input  logic [FIELD_WIDTH-1:0]    proc_time_i,
  input  logic [FIELD_WIDTH-1:0]    weight_i,
  input  logic [FIELD_WIDTH-1:0]    deadline_i,
  output logic [wtsd_pkg::CostW-1:0] min_cost_o,
  output logic                      saturated_o
);
  import wtsd_pkg::*;

  localparam int unsigned SumW   = FIELD_WIDTH + CNT_W;
  localparam int unsigned ProdW  = FIELD_WIDTH + SumW;
  localparam int unsigned ExtW   = (ProdW > CostW) ? ProdW : CostW;
  localparam int unsigned Depth  = 1 << MAX_JOBS;

  logic [FIELD_WIDTH-1:0] times_q     [MAX_JOBS];
  logic [FIELD_WIDTH-1:0] weights_q   [MAX_JOBS];
  logic [FIELD_WIDTH-1:0] deadlines_q [MAX_JOBS];
  logic [CostW-1:0]       cost_mem    [Depth];

  logic                   member;
  logic [MAX_JOBS-1:0]    rd_addr;
  logic [SumW-1:0]        done_q, done_d;
  logic [SumW-1:0]        late;
  logic [SumW-1:0]        dl_ext;

  logic                   a_valid_q;
  logic                   a_zero_q;
  logic [SumW-1:0]        a_late_q;
  logic [FIELD_WIDTH-1:0] a_weight_q;
  logic [CostW-1:0]       rd_q;

  logic [ExtW-1:0]        prod_ext;
  logic                   b_valid_q;
  logic [CostW-1:0]       b_prod_q, b_prod_d;
  logic [CostW-1:0]       b_cost_q;

  logic [CostW:0]         cand_sum;
  logic [CostW-1:0]       cand;
  logic [CostW-1:0]       best_q;
  logic                   ovf_q;
  logic [CostW-1:0]       min_cost_q;
  logic                   sat_q;

  assign member  = set_i[k_i];
  assign rd_addr = set_i & ~(MAX_JOBS'(1) << k_i);
  assign dl_ext  = SumW'(deadlines_q[k_i]);
  assign late    = (done_q > dl_ext) ? (done_q - dl_ext) : '0;

  // job store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      times_q[load_idx_i]     <= proc_time_i;
      weights_q[load_idx_i]   <= weight_i;
      deadlines_q[load_idx_i] <= deadline_i;
    end
  end

  // completion time of the current subset
  always_comb begin
    done_d = done_q;
    if (cmd_i.sum_en) begin
      done_d = (cmd_i.sum_first ? '0 : done_q) +
               (member ? SumW'(times_q[k_i]) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    done_q <= done_d;
  end

  // subset cost memory, registered read; reads only in the candidate pass,
  // so a read and a write never share a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_en) begin
      cost_mem[set_i] <= best_q;
    end else if (cmd_i.cand_issue) begin
      rd_q <= cost_mem[rd_addr];
    end
  end

  // stage a: lateness and weight of job k
  always_ff @(posedge clk_i) begin
    a_late_q   <= late;
    a_weight_q <= weights_q[k_i];
    a_zero_q   <= (rd_addr == '0);
  end

  // stage b: saturated weighted lateness, cost of the subset without k
  assign prod_ext = ExtW'(a_weight_q) * ExtW'(a_late_q);
  assign b_prod_d = (prod_ext > ExtW'(CostMax)) ? CostMax : prod_ext[CostW-1:0];

  always_ff @(posedge clk_i) begin
    b_prod_q <= b_prod_d;
    b_cost_q <= a_zero_q ? '0 : rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= cmd_i.cand_issue && member;
      b_valid_q <= a_valid_q;
    end
  end

  // stage c: saturated sum and running minimum
  assign cand_sum = {1'b0, b_cost_q} + {1'b0, b_prod_q};
  assign cand     = (cand_sum > {1'b0, CostMax}) ? CostMax : cand_sum[CostW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en && cmd_i.sum_first) begin
      best_q <= CostMax;
    end else if (b_valid_q && (cand < best_q)) begin
      best_q <= cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else if (cmd_i.clr_ovf) begin
      ovf_q <= 1'b0;
    end else if (cmd_i.write_en && (best_q == CostMax)) begin
      ovf_q <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      min_cost_q <= best_q;
      sat_q      <= ovf_q;
    end
  end

  assign min_cost_o  = min_cost_q;
  assign saturated_o = sat_q;

endmodule

// ===== src/weighted_tardiness_subset_dp_unit.sv =====
// loading: jobs load one per cycle while the unit waits in its load state;
//   after the last job the dp solves every nonempty subset, then offers the result
// throughput: one job set at a time, set by the per-subset sequence of the
//   single candidate pipeline and the one-port cost memory
// reset: asynchronous, active low; clears the sequencer, valid bits and
//   overflow flag; the cost memory, job store and result register are not cleared
// ----------------------------------------------------------------------------
// weighted_tardiness_subset_dp_unit
// minimum total weighted tardiness on one machine by dynamic programming
// over job subsets, costs saturating at 48 bits
// ----------------------------------------------------------------------------
module weighted_tardiness_subset_dp_unit #(
  parameter int unsigned MAX_JOBS    = wtsd_pkg::MaxJobsDef,
  parameter int unsigned FIELD_WIDTH = wtsd_pkg::FieldWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wtsd_job_if.sink     job_i,
  wtsd_res_if.source   res_o
);
  import wtsd_pkg::*;

  // job counter holds 0..MAX_JOBS, job index 0..MAX_JOBS-1
  localparam int unsigned CntW = $clog2(MAX_JOBS + 1);
  localparam int unsigned IdxW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  wtsd_cmd_t           cmd;
  logic [IdxW-1:0]     load_idx;
  logic [IdxW-1:0]     k;
  logic [MAX_JOBS-1:0] set;

  // sequencer: per subset, one pass over the jobs sums the completion time,
  // a second pass launches one candidate per member job, the drain states let the
  // pipeline empty and the write state stores the minimum back into the cost memory
  wtsd_ctrl #(
    .MAX_JOBS (MAX_JOBS),
    .CNT_W    (CntW),
    .IDX_W    (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_i.valid),
    .job_last_i  (job_i.last_job),
    .job_ready_o (job_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .load_idx_o  (load_idx),
    .k_o         (k),
    .set_o       (set)
  );

  // datapath: the empty subset reads as zero cost, so the memory needs no
  // initialization; every other subset is written before any superset reads it
  wtsd_dpath #(
    .MAX_JOBS    (MAX_JOBS),
    .FIELD_WIDTH (FIELD_WIDTH),
    .CNT_W       (CntW),
    .IDX_W       (IdxW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .load_idx_i  (load_idx),
    .k_i         (k),
    .set_i       (set),
    .proc_time_i (job_i.proc_time),
    .weight_i    (job_i.weight),
    .deadline_i  (job_i.deadline),
    .min_cost_o  (res_o.min_cost),
    .saturated_o (res_o.saturated)
  );

  // the empty subset is never written
  a_write_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write_en |-> (set != '0))
    else $error("cost written for the empty subset");

  // a loaded result is offered in the next cycle
  a_out_offered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> res_o.valid)
    else $error("result register loaded but not offered");

  // no job transaction while candidates are in flight
  a_no_load_in_dp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cand_issue |-> !job_i.ready)
    else $error("job input open during the dp");

  // subset writes are spaced by the sum and candidate passes
  a_write_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write_en |=> !cmd.write_en)
    else $error("back to back subset writes");

endmodule

// ===== test/weighted_tardiness_subset_dp_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_tardiness_subset_dp_unit_tb
// Drives job sets into the subset dp unit and checks every cost that comes
// back. It opens with a table of hand-picked jobs: field extremes, bit
// patterns and an overlong set whose last mark sits on an ignored job. Then
// come random job sets, mostly small, with a rare large or overlong one. A
// bit-exact cost predictor supplies the expected results. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module weighted_tardiness_subset_dp_unit_tb;
  import wtsd_pkg::*;

  localparam int unsigned Jobs         = MaxJobsDef;
  localparam int unsigned FieldW       = FieldWidthDef;
  localparam int unsigned JobTarget    = 900;
  // both channels stay quiet while the dp solves a full set of jobs
  localparam int unsigned IdleLimit    = 500_000;
  localparam int unsigned DrainCycles  = 50;
  localparam int unsigned DirectedRows = 21;

  typedef logic [FieldW-1:0] field_t;
  typedef logic [CostW-1:0]  cost_t;

  typedef struct packed {
    cost_t min_cost;
    logic  saturated;
  } cost_result_t;

  // one row of stimulus; pinned rows carry a cost worked out by hand
  typedef struct packed {
    field_t proc_time;
    field_t weight;
    field_t deadline;
    logic   last_job;
    logic   pinned;
    cost_t  pinned_cost;
  } job_row_t;

  localparam job_row_t DirectedJobs [DirectedRows] = '{
    // single jobs at the field extremes
    '{16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 48'd0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 48'd4294836225},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 48'd0},
    '{16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1, 48'd0},
    // alternating bit patterns, then a short mixed set
    '{16'hAAAA, 16'h5555, 16'h5555, 1'b1, 1'b0, 48'd0},
    '{16'h5555, 16'hAAAA, 16'hAAAA, 1'b0, 1'b0, 48'd0},
    '{16'h0003, 16'h0002, 16'h0001, 1'b0, 1'b0, 48'd0},
    '{16'h0007, 16'h0001, 16'h0004, 1'b1, 1'b0, 48'd0},
    // full store of identical jobs: cost is w * p * (1 + 2 + ... + 12)
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
    // thirteenth job is dropped, its last mark still starts the run
    '{16'h0001, 16'h0001, 16'h0000, 1'b1, 1'b1, 48'd334997225550}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  wtsd_job_if #(.FIELD_WIDTH(FieldW)) job_if ();
  wtsd_res_if                         res_if ();

  weighted_tardiness_subset_dp_unit #(
    .MAX_JOBS    (Jobs),
    .FIELD_WIDTH (FieldW)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_if),
    .res_o  (res_if)
  );

  // predictor copy of the job store and the per-subset costs
  field_t       held_time     [Jobs];
  field_t       held_weight   [Jobs];
  field_t       held_deadline [Jobs];
  int unsigned  held_count = 0;
  cost_t        subset_best   [1 << Jobs];
  cost_result_t cost_q [$];

  int unsigned  fault_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  jobs_sent   = 0;
  int unsigned  burst_left  = 0;
  bit           steady      = 1'b0;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    if (a >= CostMax || b >= CostMax || a + b > CostMax) return CostMax;
    return a + b;
  endfunction

  function automatic logic [63:0] sat_product(logic [63:0] a, logic [63:0] b);
    logic [63:0] prod;
    prod = a * b;
    if (prod > CostMax) return CostMax;
    return prod;
  endfunction

  // best order cost over all held jobs, subsets walked in ascending mask order
  function automatic cost_result_t schedule_cost(int unsigned n);
    int unsigned  full;
    logic [63:0]  finish_at;
    logic [63:0]  late;
    logic [63:0]  cand;
    logic [63:0]  best;
    cost_result_t r;
    full           = (1 << n) - 1;
    r.saturated    = 1'b0;
    subset_best[0] = '0;
    for (int unsigned s = 1; s <= full; s++) begin
      finish_at = 0;
      best      = CostMax;
      for (int unsigned k = 0; k < n; k++)
        if (((s >> k) & 1) != 0) finish_at += held_time[k];
      for (int unsigned k = 0; k < n; k++) begin
        if (((s >> k) & 1) != 0) begin
          late = (finish_at > held_deadline[k]) ? finish_at - held_deadline[k] : 0;
          cand = sat_sum(subset_best[s - (1 << k)], sat_product(held_weight[k], late));
          if (cand < best) best = cand;
        end
      end
      subset_best[s] = best[CostW-1:0];
      if (best == CostMax) r.saturated = 1'b1;
    end
    r.min_cost = subset_best[full];
    return r;
  endfunction

  // one accepted job: store it if there is room, solve on the last mark
  function automatic void take_job(job_row_t row);
    cost_result_t r;
    if (held_count < Jobs) begin
      held_time[held_count]     = row.proc_time;
      held_weight[held_count]   = row.weight;
      held_deadline[held_count] = row.deadline;
      held_count++;
    end
    if (row.last_job) begin
      r          = schedule_cost(held_count);
      held_count = 0;
      if (row.pinned) begin
        r.min_cost  = row.pinned_cost;
        r.saturated = 1'b0;
      end
      cost_q.push_back(r);
    end
  endfunction

  // called and returns at a falling edge; gaps come between bursts unless steady is set
  task automatic send_job(job_row_t row);
    if (burst_left == 0) begin
      if (!steady) begin
        job_if.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    job_if.valid     = 1'b1;
    job_if.proc_time = row.proc_time;
    job_if.weight    = row.weight;
    job_if.deadline  = row.deadline;
    job_if.last_job  = row.last_job;
    do @(posedge clk_i); while (job_if.ready !== 1'b1);
    take_job(row);
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    job_if.valid = 1'b0;
    while (cost_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic field_t pick_field(int unsigned span);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return '0;
      1:       return '1;
      2, 3:    return field_t'($urandom_range(0, 65535));
      default: return field_t'($urandom_range(0, span));
    endcase
  endfunction

  // stimulus
  initial begin
    job_row_t    row;
    int unsigned set_size;
    int unsigned span;
    int unsigned due_span;
    int unsigned roll;
    job_if.valid     = 1'b0;
    job_if.proc_time = '0;
    job_if.weight    = '0;
    job_if.deadline  = '0;
    job_if.last_job  = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirectedRows; i++) send_job(DirectedJobs[i]);
    hold_until_drained();

    while (jobs_sent < JobTarget) begin
      // mostly small sets, as the dp walks every subset of the held jobs
      roll = $urandom_range(0, 99);
      if (roll < 80)      set_size = $urandom_range(1, 5);
      else if (roll < 97) set_size = $urandom_range(6, 8);
      else if (roll < 99) set_size = $urandom_range(9, 10);
      else                set_size = $urandom_range(11, Jobs + 2);
      span     = ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(4, 200);
      due_span = (span * set_size > 65535) ? 65535 : span * set_size;
      steady   = ($urandom_range(0, 4) == 0);
      for (int unsigned j = 0; j < set_size; j++) begin
        row.proc_time   = pick_field(span);
        row.weight      = pick_field(span);
        row.deadline    = pick_field(due_span);
        row.last_job    = (j == set_size - 1);
        row.pinned      = 1'b0;
        row.pinned_cost = '0;
        send_job(row);
      end
      jobs_sent += (set_size < Jobs) ? set_size : Jobs;
      if ($urandom_range(0, 9) == 0) hold_until_drained();
    end
    job_if.valid = 1'b0;

    while (cost_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side: open stretches alternate with stalls of random length
  initial begin
    int unsigned open_left;
    int unsigned shut_left;
    open_left    = 0;
    shut_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (shut_left > 0) begin
        res_if.ready = 1'b0;
        shut_left--;
      end else begin
        res_if.ready = 1'b1;
        if (open_left > 0) begin
          open_left--;
        end else begin
          open_left = $urandom_range(0, 40);
          shut_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end
      end
    end
  end

  // compare each result transaction with the oldest expected cost
  always @(posedge clk_i) begin
    cost_result_t seen;
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (cost_q.size() == 0) begin
        $display("%0t: unexpected result, min_cost %0d saturated %0b",
                 $time, res_if.min_cost, res_if.saturated);
        fault_count++;
      end else begin
        seen = cost_q.pop_front();
        if (seen.min_cost !== res_if.min_cost) begin
          $display("%0t: min_cost expected %0d actual %0d",
                   $time, seen.min_cost, res_if.min_cost);
          fault_count++;
        end
        if (seen.saturated !== res_if.saturated) begin
          $display("%0t: saturated expected %0b actual %0b",
                   $time, seen.saturated, res_if.saturated);
          fault_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((job_if.valid === 1'b1 && job_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

endmodule

// ===== filelist.f =====
src/wtsd_pkg.sv
src/wtsd_if.sv
src/wtsd_ctrl.sv
src/wtsd_dpath.sv
src/weighted_tardiness_subset_dp_unit.sv
test/weighted_tardiness_subset_dp_unit_tb.sv
